>>> rtl/core/mlcm_pkg.sv
// shared types and constants for the memory latency channel model
// no dependencies
package mlcm_pkg;
	localparam logic [1:0] REQ_READ = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_DROP = 2'd2;
	localparam logic [0:0] REG_BASE = 1'b0;
	localparam logic [0:0] REG_PER_BYTE = 1'b1;
	localparam int CD_W = 21;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] src;
		logic [11:0] req_size;
		logic [7:0] cache_lines;
	} req_t;

	typedef struct packed {
		logic [CD_W-1:0] countdown;
		logic [1:0] req_type;
		logic [7:0] src;
		logic [11:0] req_size;
	} slot_t;
endpackage

>>> rtl/core/mlcm_ram.sv
// generic single-port-write, one-read ram with registered read
// no dependencies
module mlcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/mlcm_delay.sv
// countdown computation for an admitted request
// depends on mlcm_pkg
module mlcm_delay import mlcm_pkg::*; (
	input logic [15:0] base_latency,
	input logic [7:0] per_byte_latency,
	input req_t req,
	output logic [CD_W-1:0] countdown
);
	logic [11:0] mult_a;
	logic [19:0] prod;
	always_comb begin
		if (req.req_type == REQ_WRITE) begin
			mult_a = {req.cache_lines, 4'b0000};
		end else begin
			mult_a = req.req_size;
		end
		prod = 20'(mult_a) * 20'(per_byte_latency);
		if (req.req_type == REQ_WRITE || req.req_type == REQ_READ) begin
			countdown = CD_W'(base_latency) + CD_W'(prod);
		end else begin
			countdown = '0;
		end
	end
endmodule

>>> rtl/core/memory_latency_channel_model_unit.sv
// memory latency channel model: request fifo in ram plus slot ram
// depends on mlcm_pkg, mlcm_ram, mlcm_delay
// per item: fifo admissions, queuing of the request, a slot sweep, then the final flush;
// output stalls can hold the sweep and the flush
// throughput: one item at a time; in_ready returns once the last word has been taken
// reset: arst_n clears fifo pointers, slot count and control flags; ram contents undefined
module memory_latency_channel_model_unit import mlcm_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int CHANNELS = 4
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic op,
	input logic [1:0] req_type,
	input logic [7:0] src,
	input logic [11:0] req_size,
	input logic [7:0] cache_lines,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] resp_kind,
	output logic [7:0] dest,
	output logic [11:0] resp_size,
	output logic last
);
	localparam int QA = $clog2(QUEUE_DEPTH > 1 ? QUEUE_DEPTH : 2);
	localparam int QC = $clog2(QUEUE_DEPTH + 1);
	localparam int SA = $clog2(CHANNELS > 1 ? CHANNELS : 2);
	localparam int SC = $clog2(CHANNELS + 1);

	// sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ADMIT = 3'd1; // fifo read issued, write new slot
	localparam logic [2:0] ST_SWEEP = 3'd2; // read slot i, keep or emit
	localparam logic [2:0] ST_EMIT = 3'd3; // lets the fifo read of head settle after a push
	localparam logic [2:0] ST_DROP = 3'd4;
	localparam logic [2:0] ST_FLUSH = 3'd5; // held word leaves as last

	logic [2:0] state_q;
	logic [15:0] base_q;
	logic [7:0] per_byte_q;
	logic [QA-1:0] head_q;
	logic [QC-1:0] qcount_q;
	logic [SC-1:0] acount_q;
	logic tick_q;
	req_t req_q;
	logic pending_q; // request still to be queued
	logic [SC-1:0] idx_q; // sweep read index
	logic [SC-1:0] kept_q;
	logic rd_vld_q; // slot read data valid this cycle
	logic any_q; // a drop word has been held for this item
	logic [SC-1:0] aend_q; // slots to sweep
	// slots present before this item; only these see the tick
	logic [SC-1:0] old_cnt_q;

	// fifo ram
	logic q_we;
	logic [QA-1:0] q_waddr;
	req_t q_rdata;
	// slot ram
	logic s_we;
	logic [SA-1:0] s_waddr, s_raddr;
	slot_t s_wdata, s_rdata;
	logic [CD_W-1:0] new_cd;

	// output register with one pending word
	logic ob_v_q;
	logic [1:0] ob_kind_q;
	logic [7:0] ob_dest_q;
	logic [11:0] ob_size_q;
	logic ob_last_q;
	// held word waiting to know whether it is last
	logic hold_v_q;
	logic [1:0] hold_kind_q;
	logic [7:0] hold_dest_q;
	logic [11:0] hold_size_q;

	function automatic logic [QA-1:0] qwrap(input logic [QA:0] v);
		logic [QA:0] r;
		begin
			r = (v >= (QA+1)'(QUEUE_DEPTH)) ? v - (QA+1)'(QUEUE_DEPTH) : v;
			return r[QA-1:0];
		end
	endfunction

	mlcm_ram #(.WIDTH($bits(req_t)), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(req_q),
		.raddr(head_q), .rdata(q_rdata)
	);
	mlcm_ram #(.WIDTH($bits(slot_t)), .DEPTH(CHANNELS)) u_slots (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);
	mlcm_delay u_delay (
		.base_latency(base_q), .per_byte_latency(per_byte_q),
		.req(q_rdata), .countdown(new_cd)
	);

	assign in_ready = (state_q == ST_IDLE) && !ob_v_q && !hold_v_q;
	assign out_valid = ob_v_q;
	assign resp_kind = ob_kind_q;
	assign dest = ob_dest_q;
	assign resp_size = ob_size_q;
	assign last = ob_last_q;

	// decode of current step
	logic fifo_free, can_admit, emit_now, slot_zero;
	slot_t cur_slot;
	always_comb begin
		cur_slot = s_rdata;
		// slot idx_q-1 is on the read port; newly admitted slots keep their count
		if (tick_q && (idx_q <= old_cnt_q) && cur_slot.countdown != '0) begin
			cur_slot.countdown = cur_slot.countdown - CD_W'(1);
		end
		slot_zero = (cur_slot.countdown == '0);
		fifo_free = !ob_v_q || out_ready;
		emit_now = 1'b0;
		q_we = 1'b0;
		q_waddr = qwrap({1'b0, head_q} + (QA+1)'(qcount_q));
		s_we = 1'b0;
		s_waddr = '0;
		s_wdata = cur_slot;
		s_raddr = idx_q[SA-1:0];
		can_admit = (qcount_q != '0) && (acount_q < SC'(CHANNELS));
		unique case (state_q)
			ST_ADMIT: begin
				s_we = 1'b1;
				s_waddr = acount_q[SA-1:0];
				s_wdata = '{countdown: new_cd, req_type: q_rdata.req_type,
					src: q_rdata.src, req_size: q_rdata.req_size};
			end
			ST_DROP: begin
				// queue the pending request at the tail when there is room
				if (pending_q && qcount_q < QC'(QUEUE_DEPTH)) begin
					q_we = 1'b1;
				end
			end
			ST_SWEEP: begin
				if (rd_vld_q) begin
					if (slot_zero) begin
						emit_now = 1'b1;
					end else begin
						s_we = 1'b1;
						s_waddr = kept_q[SA-1:0];
					end
				end
			end
			default: ;
		endcase
		// stalled sweep re-reads the slot it is holding
		if (state_q == ST_SWEEP && emit_now && hold_v_q && !fifo_free) begin
			s_raddr = SA'(idx_q - SC'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			base_q <= '0;
			per_byte_q <= '0;
			head_q <= '0;
			qcount_q <= '0;
			acount_q <= '0;
			tick_q <= 1'b0;
			pending_q <= 1'b0;
			idx_q <= '0;
			kept_q <= '0;
			rd_vld_q <= 1'b0;
			any_q <= 1'b0;
			aend_q <= '0;
			old_cnt_q <= '0;
			ob_v_q <= 1'b0;
			hold_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BASE: base_q <= cfg_data;
					REG_PER_BYTE: per_byte_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (ob_v_q && out_ready) begin
				ob_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						tick_q <= op;
						pending_q <= !op;
						req_q <= '{req_type, src, req_size, cache_lines};
						any_q <= 1'b0;
						old_cnt_q <= acount_q;
						// fifo ram already reads head_q
						if (can_admit) begin
							state_q <= ST_ADMIT;
						end else if (!op) begin
							state_q <= ST_DROP;
						end else begin
							state_q <= ST_SWEEP;
							idx_q <= '0;
							kept_q <= '0;
							aend_q <= acount_q;
							rd_vld_q <= 1'b0;
						end
					end
				end
				ST_ADMIT: begin
					// slot written this cycle
					acount_q <= acount_q + SC'(1);
					head_q <= qwrap({1'b0, head_q} + (QA+1)'(1));
					qcount_q <= qcount_q - QC'(1);
					state_q <= ST_DROP;
				end
				ST_DROP: begin
					// queue request if pending (hold a drop word when full), then more admissions, then the sweep
					if (pending_q) begin
						pending_q <= 1'b0;
						if (qcount_q >= QC'(QUEUE_DEPTH)) begin
							hold_v_q <= 1'b1;
							hold_kind_q <= KIND_DROP;
							hold_dest_q <= req_q.src;
							hold_size_q <= req_q.req_size;
							any_q <= 1'b1;
						end else begin
							qcount_q <= qcount_q + QC'(1);
						end
						state_q <= ST_EMIT;
					end else if (can_admit) begin
						state_q <= ST_ADMIT;
					end else begin
						state_q <= ST_SWEEP;
						idx_q <= '0;
						kept_q <= '0;
						aend_q <= acount_q;
						rd_vld_q <= 1'b0;
					end
				end
				ST_EMIT: begin
					// lets the fifo read of head settle after a push
					state_q <= ST_DROP;
				end
				ST_SWEEP: begin
					if (!(emit_now && hold_v_q && !fifo_free)) begin
						if (rd_vld_q) begin
							if (emit_now) begin
								if (hold_v_q) begin
									ob_v_q <= 1'b1;
									ob_kind_q <= hold_kind_q;
									ob_dest_q <= hold_dest_q;
									ob_size_q <= hold_size_q;
									ob_last_q <= 1'b0;
								end
								hold_v_q <= 1'b1;
								hold_kind_q <= (cur_slot.req_type == REQ_READ) ?
									KIND_READ : KIND_WRITE;
								hold_dest_q <= cur_slot.src;
								hold_size_q <= cur_slot.req_size;
							end else begin
								kept_q <= kept_q + SC'(1);
							end
						end
						if (idx_q < aend_q) begin
							idx_q <= idx_q + SC'(1);
							rd_vld_q <= 1'b1;
						end else begin
							rd_vld_q <= 1'b0;
							acount_q <= kept_q + ((rd_vld_q && !emit_now) ? SC'(1) : SC'(0));
							state_q <= ST_IDLE;
							if (hold_v_q || emit_now) begin
								state_q <= ST_FLUSH;
							end
						end
					end
				end
				ST_FLUSH: begin
					// final word flush: hold becomes last
					if (fifo_free) begin
						ob_v_q <= 1'b1;
						ob_kind_q <= hold_kind_q;
						ob_dest_q <= hold_dest_q;
						ob_size_q <= hold_size_q;
						ob_last_q <= 1'b1;
						hold_v_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

>>> rtl/core/mlcm_checker.sv
// port-level checks for the memory latency channel model
// depends on memory_latency_channel_model_unit
module mlcm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] resp_kind,
	input logic [7:0] dest
);
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> resp_kind != 2'd3) else $error("bad kind");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dest)) else $error("word lost");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while draining");
endmodule

bind memory_latency_channel_model_unit mlcm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .resp_kind(resp_kind), .dest(dest)
);
